FILE: hw/rtl/overwrite_ring_with_lag_detect_macros.svh
// ----------------------------------------------------------------------------
// Overwrite ring assertion macros
// Concurrent assertion wrappers; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef OVERWRITE_RING_WITH_LAG_DETECT_MACROS_SVH
`define OVERWRITE_RING_WITH_LAG_DETECT_MACROS_SVH

`ifndef SYNTHESIS

// Check an implication that holds in the same cycle.
`define ORLD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("overwrite ring assertion failed");

// Check an implication that holds in the following cycle.
`define ORLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("overwrite ring assertion failed");

`else

`define ORLD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ORLD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/orld_pkg.sv
// ----------------------------------------------------------------------------
// Overwrite ring package
// Sizes, status and command codes, shared types and helper functions.
// ----------------------------------------------------------------------------
package orld_pkg;

    localparam int DEPTH         = 16;
    localparam int PAYLOAD_BYTES = 8;

    localparam int DATA_W  = 64;
    localparam int LEN_W   = 4;
    localparam int CAP_W   = 5;
    localparam int STAT_W  = 3;
    localparam int SEQ_W   = 64;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 72;

    localparam logic [CAP_W-1:0] CAPACITY_RESET   = 5'd16;
    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 4'd8;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 1'b1;

    localparam logic CMD_PUBLISH  = 1'b0;
    localparam logic CMD_RETRIEVE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_INVALID = 3'd1;
    localparam logic [STAT_W-1:0] ST_ERROR   = 3'd2;
    localparam logic [STAT_W-1:0] ST_NODATA  = 3'd3;
    localparam logic [STAT_W-1:0] ST_LOST    = 3'd4;

    typedef struct packed {
        logic [CNT_W-1:0] capacity;
        logic [LEN_W-1:0] max_length;
    } t_cfg;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] wr_slot;
        logic [IDX_W-1:0] rd_slot;
    } t_store_req;

    // Keep the low len bytes of a payload word.
    function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
        logic [DATA_W-1:0] mask;
        mask = '0;
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            mask[8*i +: 8] = (32'(len) > i) ? 8'hFF : 8'h00;
        end
        return mask;
    endfunction

    // Ring slot at base plus offset; the wrap is correct for offsets up to DEPTH.
    function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(DEPTH)) begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/orld_cfg.sv
// ----------------------------------------------------------------------------
// Overwrite ring configuration registers
// Holds capacity and max length and clamps them to their usable ranges.
// ----------------------------------------------------------------------------
module orld_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [orld_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [orld_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output orld_pkg::t_cfg                     o_cfg
);

    logic [orld_pkg::CAP_W-1:0] r_capacity;
    logic [orld_pkg::LEN_W-1:0] r_max_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity   <= orld_pkg::CAPACITY_RESET;
            r_max_length <= orld_pkg::MAX_LENGTH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                orld_pkg::REG_CAPACITY: begin
                    r_capacity <= i_cfg_wdata[orld_pkg::CAP_W-1:0];
                end
                orld_pkg::REG_MAX_LENGTH: begin
                    r_max_length <= i_cfg_wdata[orld_pkg::LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Treat zero capacity as one and cap both fields at the storage limits.
    always_comb begin
        if (r_capacity == '0) begin
            o_cfg.capacity = orld_pkg::CNT_W'(1);
        end else if (32'(r_capacity) > orld_pkg::DEPTH) begin
            o_cfg.capacity = orld_pkg::CNT_W'(orld_pkg::DEPTH);
        end else begin
            o_cfg.capacity = orld_pkg::CNT_W'(r_capacity);
        end
        if (32'(r_max_length) > orld_pkg::PAYLOAD_BYTES) begin
            o_cfg.max_length = orld_pkg::LEN_W'(orld_pkg::PAYLOAD_BYTES);
        end else begin
            o_cfg.max_length = r_max_length;
        end
    end

endmodule

FILE: hw/rtl/orld_store.sv
// ----------------------------------------------------------------------------
// Overwrite ring entry storage
// Register file of payload words and byte lengths, one write and one read.
// ----------------------------------------------------------------------------
module orld_store (
    input  logic                           i_clk,
    input  orld_pkg::t_store_req           i_req,
    input  logic [orld_pkg::DATA_W-1:0]    i_wr_data,
    input  logic [orld_pkg::LEN_W-1:0]     i_wr_length,
    output logic [orld_pkg::DATA_W-1:0]    o_rd_data,
    output logic [orld_pkg::LEN_W-1:0]     o_rd_length
);

    logic [orld_pkg::DATA_W-1:0] r_data   [orld_pkg::DEPTH];
    logic [orld_pkg::LEN_W-1:0]  r_length [orld_pkg::DEPTH];

    // Store only the valid bytes; the rest reads back as zero.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_data[i_req.wr_slot]   <= i_wr_data & orld_pkg::byte_mask(i_wr_length);
            r_length[i_req.wr_slot] <= i_wr_length;
        end
    end

    assign o_rd_data   = r_data[i_req.rd_slot];
    assign o_rd_length = r_length[i_req.rd_slot];

endmodule

FILE: hw/rtl/orld_ctrl.sv
// ----------------------------------------------------------------------------
// Overwrite ring control
// Ring pointers, sequence tracking, reader cursor and status decode.
// ----------------------------------------------------------------------------
`include "overwrite_ring_with_lag_detect_macros.svh"

module orld_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic                           i_command,
    input  logic [orld_pkg::LEN_W-1:0]     i_length,
    input  orld_pkg::t_cfg                 i_cfg,
    input  logic [orld_pkg::DATA_W-1:0]    i_rd_data,
    input  logic [orld_pkg::LEN_W-1:0]     i_rd_length,
    output orld_pkg::t_store_req           o_req,
    output logic [orld_pkg::STAT_W-1:0]    o_status,
    output logic [orld_pkg::DATA_W-1:0]    o_data,
    output logic [orld_pkg::LEN_W-1:0]     o_length
);

    localparam int CNT_W = orld_pkg::CNT_W;
    localparam int SEQ_W = orld_pkg::SEQ_W;

    logic [orld_pkg::IDX_W-1:0] r_oldest_slot, n_oldest_slot;
    logic [CNT_W-1:0]           r_fill, n_fill;
    logic [SEQ_W-1:0]           r_oldest_seq, n_oldest_seq;
    logic [SEQ_W-1:0]           r_cursor, n_cursor;

    logic             s_pub_step;
    logic             s_get_step;
    logic             s_len_invalid;
    logic             s_len_zero;
    logic             s_pub_ok;
    logic             s_drop;
    logic             s_empty;
    logic [SEQ_W-1:0] s_cur_eff;
    logic [SEQ_W:0]   s_diff;
    logic             s_lag;
    logic             s_ahead;
    logic             s_hit;
    logic [CNT_W-1:0] s_rd_off;

    assign s_pub_step = i_step && (i_command == orld_pkg::CMD_PUBLISH);
    assign s_get_step = i_step && (i_command == orld_pkg::CMD_RETRIEVE);

    assign s_len_invalid = i_length > i_cfg.max_length;
    assign s_len_zero    = i_length == '0;
    assign s_pub_ok      = !s_len_invalid && !s_len_zero;
    // Capacity is at least one, so a full ring is never empty.
    assign s_drop        = r_fill >= i_cfg.capacity;

    assign s_empty   = r_fill == '0;
    assign s_cur_eff = (r_cursor == '0) ? r_oldest_seq : r_cursor;
    assign s_diff    = {1'b0, s_cur_eff} - {1'b0, r_oldest_seq};
    assign s_lag     = s_diff[SEQ_W];
    assign s_ahead   = !s_lag && ((s_diff[SEQ_W-1:CNT_W] != '0)
                                  || (s_diff[CNT_W-1:0] >= r_fill));
    assign s_hit     = !s_empty && !s_ahead;
    assign s_rd_off  = s_lag ? '0 : s_diff[CNT_W-1:0];

    // Writing at oldest plus fill lands on the oldest slot when a ring filled to DEPTH drops.
    always_comb begin
        o_req.we      = s_pub_step && s_pub_ok;
        o_req.wr_slot = orld_pkg::slot_add(r_oldest_slot, r_fill);
        o_req.rd_slot = orld_pkg::slot_add(r_oldest_slot, s_rd_off);
    end

    always_comb begin
        n_oldest_slot = r_oldest_slot;
        n_fill        = r_fill;
        n_oldest_seq  = r_oldest_seq;
        n_cursor      = r_cursor;
        o_status      = orld_pkg::ST_OK;
        o_data        = '0;
        o_length      = '0;
        if (i_command == orld_pkg::CMD_PUBLISH) begin
            if (s_len_invalid) begin
                o_status = orld_pkg::ST_INVALID;
            end else if (s_len_zero) begin
                o_status = orld_pkg::ST_ERROR;
            end else if (s_drop) begin
                n_oldest_slot = orld_pkg::slot_add(r_oldest_slot, CNT_W'(1));
                n_oldest_seq  = r_oldest_seq + SEQ_W'(1);
            end else begin
                n_fill = r_fill + CNT_W'(1);
            end
        end else begin
            if (!s_hit) begin
                o_status = orld_pkg::ST_NODATA;
            end else begin
                o_status = s_lag ? orld_pkg::ST_LOST : orld_pkg::ST_OK;
                o_data   = i_rd_data;
                o_length = i_rd_length;
                n_cursor = s_lag ? (r_oldest_seq + SEQ_W'(1)) : (s_cur_eff + SEQ_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest_slot <= '0;
            r_fill        <= '0;
            r_oldest_seq  <= '0;
            r_cursor      <= '0;
        end else if (i_step) begin
            r_oldest_slot <= n_oldest_slot;
            r_fill        <= n_fill;
            r_oldest_seq  <= n_oldest_seq;
            r_cursor      <= n_cursor;
        end
    end

    `ORLD_ASSERT_SAME(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= CNT_W'(orld_pkg::DEPTH))
    `ORLD_ASSERT_NEXT(a_drop_keeps_fill, i_clk, i_rst_n, s_pub_step && s_pub_ok && s_drop, r_fill == $past(r_fill))
    `ORLD_ASSERT_NEXT(a_reject_holds, i_clk, i_rst_n, s_pub_step && !s_pub_ok, $stable(r_fill) && $stable(r_oldest_slot))
    `ORLD_ASSERT_NEXT(a_lost_resync, i_clk, i_rst_n, s_get_step && s_hit && s_lag, r_cursor == $past(r_oldest_seq) + SEQ_W'(1))

endmodule

FILE: hw/rtl/overwrite_ring_with_lag_detect.sv
// ----------------------------------------------------------------------------
// Overwrite ring with lag detect
// Top level: stream ports, input register, ring control and result register.
// ----------------------------------------------------------------------------
// An overwriting ring of up to 16 entries with one never-blocked writer and
// one lagging reader. Each transaction on the input stream is a publish
// (tuser = 0) or a retrieve (tuser = 1) and yields exactly one result
// transaction. Throughput is one transaction per clock while the result
// stream is not stalled. An item goes from the input register, through one
// pass of the ring update, into the result register; a stalled result
// register holds the input register, and the input stream stalls only
// while both are full. The rate is set by that single pass: the ring
// pointers, the oldest sequence number and the reader cursor all update
// in the cycle an item leaves the input register, so the next item always
// sees the new state. The reader cursor is compared against the oldest
// live sequence number with one 65-bit subtract; a cursor that fell behind
// returns the oldest entry with data lost status and resyncs.
// Configuration writes must only happen with both registers empty.
// ----------------------------------------------------------------------------
module overwrite_ring_with_lag_detect (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write port
    input  logic                                 i_cfg_we,
    input  logic [orld_pkg::CFG_IDX_W-1:0]       i_cfg_addr,
    input  logic [orld_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    // Input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [orld_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // payload[63:0], length[67:64]
    input  logic                                 s_axis_tuser,  // command
    // Result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [orld_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // read_data[63:0], read_length[67:64]
    output logic [orld_pkg::STAT_W-1:0]          m_axis_tuser   // status
);

    localparam int DATA_W = orld_pkg::DATA_W;
    localparam int LEN_W  = orld_pkg::LEN_W;

    // Input register
    logic              r_in_valid;
    logic              r_in_cmd;
    logic [DATA_W-1:0] r_in_payload;
    logic [LEN_W-1:0]  r_in_length;

    // Result register
    logic                        r_out_valid;
    logic [orld_pkg::STAT_W-1:0] r_out_status;
    logic [DATA_W-1:0]           r_out_data;
    logic [LEN_W-1:0]            r_out_length;

    logic                        s_advance;
    logic                        s_step;
    orld_pkg::t_cfg              s_cfg;
    orld_pkg::t_store_req        s_req;
    logic [DATA_W-1:0]           s_rd_data;
    logic [LEN_W-1:0]            s_rd_length;
    logic [orld_pkg::STAT_W-1:0] s_status;
    logic [DATA_W-1:0]           s_data;
    logic [LEN_W-1:0]            s_length;

    // Advance the held item whenever the result register is free or draining.
    assign s_advance     = !r_out_valid || m_axis_tready;
    assign s_step        = r_in_valid && s_advance;
    assign s_axis_tready = !r_in_valid || s_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (s_step) begin
            r_in_valid <= 1'b0;
        end
    end

    // Capture the transaction fields.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd     <= s_axis_tuser;
            r_in_payload <= s_axis_tdata[DATA_W-1:0];
            r_in_length  <= s_axis_tdata[DATA_W +: LEN_W];
        end
    end

    orld_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (s_cfg)
    );

    orld_store u_store (
        .i_clk       (i_clk),
        .i_req       (s_req),
        .i_wr_data   (r_in_payload),
        .i_wr_length (r_in_length),
        .o_rd_data   (s_rd_data),
        .o_rd_length (s_rd_length)
    );

    orld_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (s_step),
        .i_command   (r_in_cmd),
        .i_length    (r_in_length),
        .i_cfg       (s_cfg),
        .i_rd_data   (s_rd_data),
        .i_rd_length (s_rd_length),
        .o_req       (s_req),
        .o_status    (s_status),
        .o_data      (s_data),
        .o_length    (s_length)
    );

    // Hold the result until the downstream side takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_step) begin
            r_out_status <= s_status;
            r_out_data   <= s_data;
            r_out_length <= s_length;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {(orld_pkg::OUT_TDATA_W - DATA_W - LEN_W)'(0), r_out_length, r_out_data};

endmodule

FILE: bench/tb_overwrite_ring_with_lag_detect.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Overwrite ring with lag detect testbench
// Drives publish and retrieve transactions into the ring, keeps a transaction-level
// shadow of the ring, its sequence numbers and the reader cursor, and checks
// every result transaction field by field in order. Capacity and length limit
// are rewritten between phases, extremes included, while the ring is quiet.
// ----------------------------------------------------------------------------
module tb_overwrite_ring_with_lag_detect;

    localparam int DATA_W        = orld_pkg::DATA_W;
    localparam int LEN_W         = orld_pkg::LEN_W;
    localparam int STAT_W        = orld_pkg::STAT_W;
    localparam int IDX_W         = orld_pkg::IDX_W;
    localparam int CNT_W         = orld_pkg::CNT_W;
    localparam int SEQ_W         = orld_pkg::SEQ_W;
    localparam int CAP_W         = orld_pkg::CAP_W;
    localparam int DEPTH         = orld_pkg::DEPTH;
    localparam int PAYLOAD_BYTES = orld_pkg::PAYLOAD_BYTES;

    localparam int RUN_LIMIT    = 400000;
    localparam int PHASE_ITEMS  = 125;
    localparam int PHASE_COUNT  = 12;

    // One input transaction as the testbench sees it.
    typedef struct {
        logic                cmd;
        logic [DATA_W-1:0]   payload;
        logic [LEN_W-1:0]    length;
    } t_ring_cmd;

    // One result transaction.
    typedef struct {
        logic [STAT_W-1:0]   status;
        logic [DATA_W-1:0]   data;
        logic [LEN_W-1:0]    length;
    } t_ring_result;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_cfg_we;
    logic [orld_pkg::CFG_IDX_W-1:0]       i_cfg_addr;
    logic [orld_pkg::CFG_DATA_W-1:0]      i_cfg_wdata;
    logic                                 s_axis_tvalid = 1'b0;
    logic                                 s_axis_tready;
    logic [orld_pkg::IN_TDATA_W-1:0]      s_axis_tdata  = '0;  // payload[63:0], length[67:64]
    logic                                 s_axis_tuser  = orld_pkg::CMD_PUBLISH;  // command
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready = 1'b0;
    logic [orld_pkg::OUT_TDATA_W-1:0]     m_axis_tdata;  // read_data[63:0], read_length[67:64]
    logic [STAT_W-1:0]                    m_axis_tuser;  // status

    overwrite_ring_with_lag_detect dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // ------------------------------------------------------------------------
    // Shadow ring: contents, pointers, sequence numbers, reader cursor and the
    // two configuration registers, all at their reset values.
    // ------------------------------------------------------------------------
    logic [DATA_W-1:0]  shadow_data [DEPTH] = '{default: '0};
    logic [LEN_W-1:0]   shadow_len  [DEPTH] = '{default: '0};
    logic [IDX_W-1:0]   shadow_head   = '0;
    logic [CNT_W-1:0]   shadow_fill   = '0;
    logic [SEQ_W-1:0]   shadow_seq    = '0;
    logic [SEQ_W-1:0]   shadow_cursor = '0;
    logic [CAP_W-1:0]   cfg_capacity  = orld_pkg::CAPACITY_RESET;
    logic [LEN_W-1:0]   cfg_max_len   = orld_pkg::MAX_LENGTH_RESET;

    t_ring_cmd          pending_cmds[$];      // transactions not yet offered
    t_ring_result       expected_results[$];  // predicted, not yet seen
    t_ring_cmd          drv_cmd;              // transaction on the input bus
    logic               in_taken = 1'b0;      // input bus moved at last edge
    logic               idle_en  = 1'b1;      // random idling on both sides
    int                 src_hold = 0;
    int                 snk_hold = 0;
    int                 cycle_count = 0;
    int                 fail_count  = 0;

    // Apply one transaction to the shadow ring and return its result.
    function automatic t_ring_result predict_ring(t_ring_cmd c);
        t_ring_result        r;
        logic [CAP_W-1:0]    cap_eff;
        logic [LEN_W-1:0]    len_lim;
        logic [SEQ_W-1:0]    oldest_seq;
        logic [SEQ_W-1:0]    offset;
        logic [IDX_W-1:0]    slot;
        logic [DATA_W-1:0]   keep;
        r.status = orld_pkg::ST_OK;
        r.data   = '0;
        r.length = '0;
        // Out-of-range settings clamp to what the ring can hold.
        cap_eff = (cfg_capacity == 0) ? CAP_W'(1) :
                  (cfg_capacity > DEPTH) ? CAP_W'(DEPTH) : cfg_capacity;
        len_lim = (cfg_max_len > PAYLOAD_BYTES) ? LEN_W'(PAYLOAD_BYTES) : cfg_max_len;
        if (c.cmd == orld_pkg::CMD_PUBLISH) begin
            // Length limit is checked ahead of the empty publish.
            if (c.length > len_lim) begin
                r.status = orld_pkg::ST_INVALID;
            end else if (c.length == 0) begin
                r.status = orld_pkg::ST_ERROR;
            end else begin
                // Full (or over a lowered capacity): drop the oldest first.
                if (shadow_fill >= cap_eff) begin
                    shadow_head = shadow_head + 1'b1;
                    shadow_fill = shadow_fill - 1'b1;
                end
                slot = shadow_head + shadow_fill[IDX_W-1:0];
                keep = '0;
                for (int b = 0; b < PAYLOAD_BYTES; b++) begin
                    if (b < c.length) keep[8*b +: 8] = 8'hFF;
                end
                shadow_data[slot] = c.payload & keep;
                shadow_len[slot]  = c.length;
                shadow_fill = shadow_fill + 1'b1;
                shadow_seq  = shadow_seq + 1'b1;
            end
        end else if (shadow_fill == 0) begin
            // Empty ring: cursor stays where it is.
            r.status = orld_pkg::ST_NODATA;
        end else begin
            oldest_seq = shadow_seq - SEQ_W'(shadow_fill);
            // A cursor of zero has not started yet: begin at the oldest.
            if (shadow_cursor == 0) shadow_cursor = oldest_seq;
            if (shadow_cursor >= oldest_seq) begin
                offset = shadow_cursor - oldest_seq;
                if (offset >= SEQ_W'(shadow_fill)) r.status = orld_pkg::ST_NODATA;
            end else begin
                // Reader fell behind an overwrite: resync to the oldest.
                offset   = '0;
                r.status = orld_pkg::ST_LOST;
            end
            if (r.status != orld_pkg::ST_NODATA) begin
                slot          = shadow_head + offset[IDX_W-1:0];
                r.data        = shadow_data[slot];
                r.length      = shadow_len[slot];
                shadow_cursor = oldest_seq + offset + 1'b1;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Input driver: change the bus at the falling edge, hold a transaction
    // until it is taken, and insert idle bursts at random.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_ring_cmd nxt;
        logic      load;
        if (i_rst_n && (!s_axis_tvalid || in_taken)) begin
            load = 1'b0;
            if (src_hold > 0) begin
                src_hold = src_hold - 1;
            end else if (pending_cmds.size() != 0) begin
                if (idle_en && $urandom_range(0, 7) == 0) begin
                    src_hold = $urandom_range(0, 8);
                end else begin
                    nxt  = pending_cmds[0];
                    pending_cmds.delete(0);
                    load = 1'b1;
                end
            end
            if (load) begin
                drv_cmd       <= nxt;
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {{(orld_pkg::IN_TDATA_W - DATA_W - LEN_W){1'b0}},
                                  nxt.length, nxt.payload};
                s_axis_tuser  <= nxt.cmd;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result sink: stall in random bursts.
    always @(negedge i_clk) begin
        if (snk_hold > 0) begin
            snk_hold = snk_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            snk_hold = $urandom_range(0, 8);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: sample at the rising edge, track register writes, predict every
    // accepted input transaction and compare each result with the oldest
    // prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_ring_result want;
        t_ring_result got;
        cycle_count = cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("%0t: run limit reached, %0d results still due",
                     $time, expected_results.size());
            $display("TB_ERROR");
            $finish;
        end else if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    orld_pkg::REG_CAPACITY:   cfg_capacity = i_cfg_wdata[CAP_W-1:0];
                    orld_pkg::REG_MAX_LENGTH: cfg_max_len  = i_cfg_wdata[LEN_W-1:0];
                    default: ;
                endcase
            end
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.insert(expected_results.size(), predict_ring(drv_cmd));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.status = m_axis_tuser;
                got.data   = m_axis_tdata[DATA_W-1:0];
                got.length = m_axis_tdata[DATA_W +: LEN_W];
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got status %0d",
                             $time, got.status);
                    fail_count++;
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, got.status);
                        fail_count++;
                    end
                    if (got.data !== want.data) begin
                        $display("%0t: read_data expected %h got %h",
                                 $time, want.data, got.data);
                        fail_count++;
                    end
                    if (got.length !== want.length) begin
                        $display("%0t: read_length expected %0d got %0d",
                                 $time, want.length, got.length);
                        fail_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic queue_cmd(input logic cmd, input logic [DATA_W-1:0] payload,
                             input logic [LEN_W-1:0] length);
        t_ring_cmd c;
        c.cmd     = cmd;
        c.payload = payload;
        c.length  = length;
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    // Hold until every queued transaction has produced its result, then let
    // the two-stage pipe settle.
    task automatic wait_drained();
        while (pending_cmds.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [orld_pkg::CFG_IDX_W-1:0] idx,
                             input logic [orld_pkg::CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] pick_payload();
        case ($urandom_range(0, 7))
            0:       return '1;
            1:       return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly lengths the limit accepts, with empty and over-long ones mixed in.
    function automatic logic [LEN_W-1:0] pick_length(input int lim);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return LEN_W'($urandom_range(0, PAYLOAD_BYTES));
            default: return LEN_W'($urandom_range(1, (lim < 1) ? 1 : lim));
        endcase
    endfunction

    initial begin
        int cap_set;
        int len_set;
        int lim;
        int pub_pct;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = orld_pkg::REG_CAPACITY;
        i_cfg_wdata   = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at reset settings: empty retrieve, empty publish,
        // widest and narrowest payloads, reader catching up, then an overrun
        // that forces data lost and a resync.
        queue_cmd(orld_pkg::CMD_RETRIEVE, '0, '0);
        queue_cmd(orld_pkg::CMD_PUBLISH, '1, 4'd0);
        queue_cmd(orld_pkg::CMD_PUBLISH, '1, 4'd8);
        queue_cmd(orld_pkg::CMD_PUBLISH, '1, 4'd1);
        queue_cmd(orld_pkg::CMD_RETRIEVE, '0, '0);
        queue_cmd(orld_pkg::CMD_RETRIEVE, '0, '0);
        queue_cmd(orld_pkg::CMD_RETRIEVE, '0, '0);
        for (int i = 0; i < DEPTH + 2; i++)
            queue_cmd(orld_pkg::CMD_PUBLISH, {$urandom, $urandom},
                      LEN_W'(i % PAYLOAD_BYTES + 1));
        queue_cmd(orld_pkg::CMD_RETRIEVE, '0, '0);
        queue_cmd(orld_pkg::CMD_RETRIEVE, '0, '0);

        // Random phases. The first few walk the register extremes (zero and
        // all-ones included); capacity drops below the fill along the way.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            wait_drained();
            case (p)
                0:       begin cap_set = 0;  len_set = 0;  end
                1:       begin cap_set = 31; len_set = 15; end
                2:       begin cap_set = 2;  len_set = 3;  end
                3:       begin cap_set = 16; len_set = 8;  end
                4:       begin cap_set = 1;  len_set = 1;  end
                5:       begin cap_set = 17; len_set = 7;  end
                default: begin
                    cap_set = $urandom_range(0, 31);
                    len_set = $urandom_range(0, 15);
                end
            endcase
            write_reg(orld_pkg::REG_CAPACITY, orld_pkg::CFG_DATA_W'(cap_set));
            write_reg(orld_pkg::REG_MAX_LENGTH, orld_pkg::CFG_DATA_W'(len_set));
            lim = (len_set > PAYLOAD_BYTES) ? PAYLOAD_BYTES : len_set;
            // Vary the publish share so the reader both laps and trails.
            case ($urandom_range(0, 3))
                0:       pub_pct = 25;
                1:       pub_pct = 50;
                2:       pub_pct = 70;
                default: pub_pct = 90;
            endcase
            // Final phase runs with no idling; others mostly idle at random.
            idle_en = (p != PHASE_COUNT - 1) && ($urandom_range(0, 3) != 0);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 99) < pub_pct)
                    queue_cmd(orld_pkg::CMD_PUBLISH, pick_payload(), pick_length(lim));
                else
                    queue_cmd(orld_pkg::CMD_RETRIEVE, pick_payload(), pick_length(lim));
            end
        end

        wait_drained();
        repeat (6) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
